// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, all clocked on clk_i and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/tmqp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tmqp_pkg;

  localparam int unsigned NumQueuesDef  = 16;
  localparam int unsigned NumHeadersDef = 64;

  localparam int unsigned ByteW    = 16;
  localparam int unsigned TypeW    = 31;
  localparam int unsigned SlotW    = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ByteW-1:0] DefaultQuotaRst = 16'd16384;
  localparam logic [ByteW-1:0] MaxMessageRst   = 16'd8192;

  localparam logic [CfgIdxW-1:0] CfgDefaultQuota = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxMessage   = 1'b1;

  localparam logic [2:0] OpCreate   = 3'd0;
  localparam logic [2:0] OpSend     = 3'd1;
  localparam logic [2:0] OpReceive  = 3'd2;
  localparam logic [2:0] OpRemove   = 3'd3;
  localparam logic [2:0] OpSetQuota = 3'd4;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StInvalid   = 3'd1,
    StNoQueue   = 3'd2,
    StFull      = 3'd3,
    StNoMessage = 3'd4,
    StTooBig    = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]        op;
    logic [3:0]        queue;
    logic signed [31:0] type_value;
    logic [ByteW-1:0]  byte_count;
    logic              truncate_ok;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [TypeW-1:0]  got_type;
    logic [ByteW-1:0]  got_bytes;
    logic [SlotW-1:0]  slot;
  } rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/typed_message_queue_pool.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Typed message queue pool: NUM_QUEUES fifo queues share NUM_HEADERS message headers
// held on one free list. An item is taken when start_i is high and busy_o is low; its
// result shows on rsp_o while done_o is high for exactly one cycle, and must be captured
// then, since the receiver cannot stall the block. One item is worked at a time: create,
// set quota and items rejected at decode end in S_DECODE; a send adds S_SEND_POP and,
// on a non-empty queue, S_SEND_LINK; a receive walks in S_RECV_WALK (a zero selector
// walks one header), then ends in S_RECV_DONE or S_RECV_FREE; a remove frees each header
// in S_REM_WALK. The walk is set by the single read port of the header memory, one linked
// header per cycle. Config writes are always ready and should be made while busy_o is low.
module typed_message_queue_pool #(
  parameter int unsigned NUM_QUEUES  = tmqp_pkg::NumQueuesDef,
  parameter int unsigned NUM_HEADERS = tmqp_pkg::NumHeadersDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  tmqp_pkg::req_t                 req_i,
  output logic                           busy_o,
  output logic                           done_o,
  output tmqp_pkg::rsp_t                 rsp_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tmqp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tmqp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tmqp_pkg::*;

  // header index carries one extra code for "none"
  localparam int unsigned HW = $clog2(NUM_HEADERS + 1);
  localparam int unsigned AW = $clog2(NUM_HEADERS);
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [HW-1:0] Nil = HW'(NUM_HEADERS);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_DECODE    = 8'b0000_0010,
    S_SEND_POP  = 8'b0000_0100,
    S_SEND_LINK = 8'b0000_1000,
    S_RECV_WALK = 8'b0001_0000,
    S_RECV_DONE = 8'b0010_0000,
    S_RECV_FREE = 8'b0100_0000,
    S_REM_WALK  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [ByteW-1:0] dflt_quota_q, max_msg_q;

  // latched item
  req_t req_q;

  // per-queue state; only in_use has a reset, the rest is set by create
  logic [NUM_QUEUES-1:0] in_use_q;
  logic [HW-1:0]    qfirst_q [NUM_QUEUES];
  logic [HW-1:0]    qlast_q  [NUM_QUEUES];
  logic [ByteW-1:0] qused_q  [NUM_QUEUES];
  logic [ByteW-1:0] qquota_q [NUM_QUEUES];

  // header memories, one read address shared by all three
  logic [HW-1:0]    nx_mem [NUM_HEADERS];
  logic [TypeW-1:0] ty_mem [NUM_HEADERS];
  logic [ByteW-1:0] by_mem [NUM_HEADERS];
  logic [HW-1:0]    nx_rd_q;
  logic [TypeW-1:0] ty_rd_q;
  logic [ByteW-1:0] by_rd_q;

  // free list head, and first header never touched since reset; the untouched
  // headers form the tail of the free list in index order
  logic [HW-1:0] free_q, free_d;
  logic [HW-1:0] fresh_q, fresh_d;

  // walk registers
  logic [HW-1:0]    cur_q, cur_d, prev_q, prev_d;
  logic [HW-1:0]    best_q, best_d, bprev_q, bprev_d, bnext_q, bnext_d;
  logic [TypeW-1:0] btype_q, btype_d;
  logic [ByteW-1:0] bbytes_q, bbytes_d;

  rsp_t res_q, res_d;
  logic done_q, done_d;
  logic res_we;

  // queue update controls
  logic [QW-1:0]    qi;
  logic             q_ok;
  logic [HW-1:0]    qf, ql, qf_d, ql_d;
  logic [ByteW-1:0] used, quota, used_d, quota_d;
  logic             q_we, use_set, use_clr;

  // memory controls
  logic             nx_we, hd_we;
  logic [HW-1:0]    nx_waddr, nx_wdata, rd_addr;

  // selector decode
  logic [31:0]      tv_u, mag;
  logic             sel_zero, sel_pos, sel_neg;
  logic [ByteW:0]   quota_sum;
  logic             take, stop;

  assign qi    = QW'(req_q.queue);
  assign q_ok  = (32'(req_q.queue) < NUM_QUEUES);
  assign qf    = qfirst_q[qi];
  assign ql    = qlast_q[qi];
  assign used  = qused_q[qi];
  assign quota = qquota_q[qi];

  assign tv_u     = req_q.type_value;
  assign mag      = ~tv_u + 32'd1;
  assign sel_zero = (tv_u == 32'd0);
  assign sel_neg  = tv_u[31];
  assign sel_pos  = !sel_neg && !sel_zero;
  assign quota_sum = {1'b0, req_q.byte_count} + {1'b0, used};

  // candidate test for the header on the memory output
  always_comb begin
    take = 1'b0;
    stop = (nx_rd_q == Nil);
    if (sel_zero) begin
      take = 1'b1;
      stop = 1'b1;
    end else if (sel_pos) begin
      if ({1'b0, ty_rd_q} == tv_u) begin
        take = 1'b1;
        stop = 1'b1;
      end
    end else if (({1'b0, ty_rd_q} <= mag) && ((best_q == Nil) || (btype_q > ty_rd_q))) begin
      take = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    best_d   = best_q;
    bprev_d  = bprev_q;
    bnext_d  = bnext_q;
    btype_d  = btype_q;
    bbytes_d = bbytes_q;
    free_d   = free_q;
    fresh_d  = fresh_q;
    q_we     = 1'b0;
    qf_d     = qf;
    ql_d     = ql;
    used_d   = used;
    quota_d  = quota;
    use_set  = 1'b0;
    use_clr  = 1'b0;
    nx_we    = 1'b0;
    nx_waddr = cur_q;
    nx_wdata = Nil;
    hd_we    = 1'b0;
    rd_addr  = cur_q;
    res_we   = 1'b0;
    res_d    = res_q;
    done_d   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        res_d.status    = StOk;
        res_d.got_type  = '0;
        res_d.got_bytes = '0;
        res_d.slot      = '0;
        res_we  = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (req_q.op > OpSetQuota) begin
          res_d.status = StInvalid;
        end else if (!q_ok) begin
          res_d.status = StNoQueue;
        end else if (req_q.op == OpCreate) begin
          if (!in_use_q[qi]) begin
            use_set = 1'b1;
            q_we    = 1'b1;
            qf_d    = Nil;
            ql_d    = Nil;
            used_d  = '0;
            quota_d = dflt_quota_q;
          end
        end else if (!in_use_q[qi]) begin
          res_d.status = StNoQueue;
        end else begin
          case (req_q.op)
            OpSend: begin
              if ((req_q.byte_count > max_msg_q) || sel_neg || sel_zero) begin
                res_d.status = StInvalid;
              end else if ((quota_sum > {1'b0, quota}) || (free_q == Nil)) begin
                res_d.status = StFull;
              end else begin
                // fetch the successor of the free head
                rd_addr = free_q;
                res_we  = 1'b0;
                done_d  = 1'b0;
                state_d = S_SEND_POP;
              end
            end
            OpReceive: begin
              if (qf == Nil) begin
                res_d.status = StNoMessage;
              end else begin
                rd_addr = qf;
                cur_d   = qf;
                prev_d  = Nil;
                best_d  = Nil;
                res_we  = 1'b0;
                done_d  = 1'b0;
                state_d = S_RECV_WALK;
              end
            end
            OpRemove: begin
              // result is already final, the walk only frees headers
              use_clr = 1'b1;
              q_we    = 1'b1;
              qf_d    = Nil;
              ql_d    = Nil;
              used_d  = '0;
              if (qf != Nil) begin
                rd_addr = qf;
                cur_d   = qf;
                done_d  = 1'b0;
                state_d = S_REM_WALK;
              end
            end
            default: begin
              // set quota, any value
              q_we    = 1'b1;
              quota_d = req_q.byte_count;
            end
          endcase
        end
      end

      S_SEND_POP: begin
        // untouched headers chain to the next index
        if (free_q == fresh_q) begin
          free_d  = HW'(free_q + 1'b1);
          fresh_d = HW'(fresh_q + 1'b1);
        end else begin
          free_d = nx_rd_q;
        end
        nx_we    = 1'b1;
        nx_waddr = free_q;
        nx_wdata = Nil;
        hd_we    = 1'b1;
        q_we     = 1'b1;
        if (qf == Nil) begin
          qf_d = free_q;
        end
        ql_d   = free_q;
        used_d = quota_sum[ByteW-1:0];
        cur_d  = free_q;
        prev_d = ql;
        res_we = 1'b1;
        res_d.status    = StOk;
        res_d.got_type  = '0;
        res_d.got_bytes = '0;
        res_d.slot      = SlotW'(free_q);
        if (qf == Nil) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_SEND_LINK;
        end
      end

      S_SEND_LINK: begin
        nx_we    = 1'b1;
        nx_waddr = prev_q;
        nx_wdata = cur_q;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end

      S_RECV_WALK: begin
        if (take) begin
          best_d   = cur_q;
          bprev_d  = prev_q;
          bnext_d  = nx_rd_q;
          btype_d  = ty_rd_q;
          bbytes_d = by_rd_q;
        end
        if (stop) begin
          state_d = S_RECV_DONE;
        end else begin
          prev_d  = cur_q;
          cur_d   = nx_rd_q;
          rd_addr = nx_rd_q;
        end
      end

      S_RECV_DONE: begin
        res_we          = 1'b1;
        res_d.status    = StOk;
        res_d.got_type  = '0;
        res_d.got_bytes = '0;
        res_d.slot      = '0;
        if (best_q == Nil) begin
          res_d.status = StNoMessage;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if ((req_q.byte_count < bbytes_q) && !req_q.truncate_ok) begin
          res_d.status = StTooBig;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          res_d.got_type  = btype_q;
          res_d.got_bytes = (req_q.byte_count < bbytes_q) ? req_q.byte_count : bbytes_q;
          res_d.slot      = SlotW'(best_q);
          q_we   = 1'b1;
          used_d = (used >= bbytes_q) ? (used - bbytes_q) : '0;
          // unlink from the queue
          if (bprev_q == Nil) begin
            qf_d = bnext_q;
          end else begin
            nx_we    = 1'b1;
            nx_waddr = bprev_q;
            nx_wdata = bnext_q;
          end
          if (bnext_q == Nil) begin
            ql_d = bprev_q;
          end
          state_d = S_RECV_FREE;
        end
      end

      S_RECV_FREE: begin
        nx_we    = 1'b1;
        nx_waddr = best_q;
        nx_wdata = free_q;
        free_d   = best_q;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end

      S_REM_WALK: begin
        // push the current header, follow its old link
        nx_we    = 1'b1;
        nx_waddr = cur_q;
        nx_wdata = free_q;
        free_d   = cur_q;
        if (nx_rd_q == Nil) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cur_d   = nx_rd_q;
          rd_addr = nx_rd_q;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      done_q       <= 1'b0;
      free_q       <= '0;
      fresh_q      <= '0;
      in_use_q     <= '0;
      dflt_quota_q <= DefaultQuotaRst;
      max_msg_q    <= MaxMessageRst;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      free_q  <= free_d;
      fresh_q <= fresh_d;
      if (use_set) begin
        in_use_q[qi] <= 1'b1;
      end else if (use_clr) begin
        in_use_q[qi] <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgDefaultQuota: dflt_quota_q <= cfg_data_i;
          CfgMaxMessage:   max_msg_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    best_q   <= best_d;
    bprev_q  <= bprev_d;
    bnext_q  <= bnext_d;
    btype_q  <= btype_d;
    bbytes_q <= bbytes_d;
    if (res_we) begin
      res_q <= res_d;
    end
    if (q_we) begin
      qfirst_q[qi] <= qf_d;
      qlast_q[qi]  <= ql_d;
      qused_q[qi]  <= used_d;
      qquota_q[qi] <= quota_d;
    end
  end

  // header memories
  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      nx_mem[nx_waddr[AW-1:0]] <= nx_wdata;
    end
    if (hd_we) begin
      ty_mem[free_q[AW-1:0]] <= tv_u[TypeW-1:0];
      by_mem[free_q[AW-1:0]] <= req_q.byte_count;
    end
    nx_rd_q <= nx_mem[rd_addr[AW-1:0]];
    ty_rd_q <= ty_mem[rd_addr[AW-1:0]];
    by_rd_q <= by_mem[rd_addr[AW-1:0]];
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign rsp_o       = res_q;
  assign cfg_ready_o = 1'b1;

`include "assert_macros.svh"

  // result strobe comes with the sequencer back at rest
  `ASSERT_IMPLIES(a_done_idle, done_q, state_q == S_IDLE)
  // an accepted item always makes the block busy
  `ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o)
  // untouched-header mark never runs past the pool
  `ASSERT_ALWAYS(a_fresh_range, fresh_q <= Nil)
  // the free head is a real header or none, never beyond
  `ASSERT_ALWAYS(a_free_range, free_q <= Nil)

endmodule
`default_nettype wire
